>>> hdl/pcst_pkg.sv
// Package for the Pearson chi-square table block.
// Holds the controller states, datapath operation codes, status struct and fixed widths.
// No dependencies.
package pcst_pkg;

    localparam int CFGW       = 3;
    localparam int CFG_IDXW   = 2;
    localparam int OUT_W      = 40;
    localparam int ACC_W      = 64;
    localparam int GUARD_BITS = 8;

    localparam logic [CFG_IDXW-1:0] REG_ROWS = CFG_IDXW'(0);
    localparam logic [CFG_IDXW-1:0] REG_COLS = CFG_IDXW'(1);

    localparam logic [CFGW-1:0] ROWS_RESET = CFGW'(2);
    localparam logic [CFGW-1:0] COLS_RESET = CFGW'(3);

    typedef enum logic [3:0] {
        S_LOAD,
        S_CHECK,
        S_READ,
        S_PROD,
        S_DIFF,
        S_MDD,
        S_MDD_RUN,
        S_MDEN,
        S_MDEN_RUN,
        S_DSTART,
        S_DRUN,
        S_ACC,
        S_FINISH,
        S_FIN_DEGEN
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CFG,
        OP_LOAD,
        OP_READ,
        OP_PROD,
        OP_DIFF,
        OP_MSTART_DD,
        OP_MSTART_DEN,
        OP_MSTEP,
        OP_DSTART,
        OP_DSTEP,
        OP_ACC,
        OP_RESULT,
        OP_RESULT_DEGEN
    } t_dp_op;

    typedef struct packed {
        logic last_cell;
        logic degen;
        logic last_k;
        logic step_last;
    } t_dp_status;

endpackage

>>> hdl/pcst_ctrl.sv
// Controller state machine for the Pearson chi-square table block.
// Sequences loading, per-cell arithmetic and result hand-off; depends on pcst_pkg.
module pcst_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cell_valid,
    output logic                o_cell_stall,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    output logic                o_res_valid,
    input  logic                i_res_stall,
    input  pcst_pkg::t_dp_status i_status,
    output pcst_pkg::t_dp_op    o_op
);
    import pcst_pkg::*;

    t_state r_state, n_state;
    logic   r_res_valid, n_res_valid;
    logic   emit_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    assign emit_ok = !r_res_valid || !i_res_stall;

    always_comb begin
        n_state      = r_state;
        n_res_valid  = r_res_valid && i_res_stall;
        o_op         = OP_NONE;
        o_cell_stall = 1'b1;
        o_cfg_ready  = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_cfg_ready  = 1'b1;
                o_cell_stall = i_cfg_valid;
                if (i_cfg_valid) begin
                    o_op = OP_CFG;
                end else if (i_cell_valid) begin
                    o_op = OP_LOAD;
                    if (i_status.last_cell) n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_status.degen ? S_FIN_DEGEN : S_READ;
            end
            S_READ: begin
                o_op    = OP_READ;
                n_state = S_PROD;
            end
            S_PROD: begin
                o_op    = OP_PROD;
                n_state = S_DIFF;
            end
            S_DIFF: begin
                o_op    = OP_DIFF;
                n_state = S_MDD;
            end
            S_MDD: begin
                o_op    = OP_MSTART_DD;
                n_state = S_MDD_RUN;
            end
            S_MDD_RUN: begin
                o_op = OP_MSTEP;
                if (i_status.step_last) n_state = S_MDEN;
            end
            S_MDEN: begin
                o_op    = OP_MSTART_DEN;
                n_state = S_MDEN_RUN;
            end
            S_MDEN_RUN: begin
                o_op = OP_MSTEP;
                if (i_status.step_last) n_state = S_DSTART;
            end
            S_DSTART: begin
                o_op    = OP_DSTART;
                n_state = S_DRUN;
            end
            S_DRUN: begin
                o_op = OP_DSTEP;
                if (i_status.step_last) n_state = S_ACC;
            end
            S_ACC: begin
                o_op    = OP_ACC;
                n_state = i_status.last_k ? S_FINISH : S_READ;
            end
            S_FINISH: begin
                if (emit_ok) begin
                    o_op        = OP_RESULT;
                    n_res_valid = 1'b1;
                    n_state     = S_LOAD;
                end
            end
            S_FIN_DEGEN: begin
                if (emit_ok) begin
                    o_op        = OP_RESULT_DEGEN;
                    n_res_valid = 1'b1;
                    n_state     = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_res_valid = r_res_valid;

endmodule

>>> hdl/pcst_dp.sv
// Datapath for the Pearson chi-square table block: cell memory, sums,
// shared serial multiplier, restoring divider, accumulator and result register.
// Depends on pcst_pkg.
module pcst_dp #(
    parameter int MAX_ROWS   = 4,
    parameter int MAX_COLS   = 4,
    parameter int COUNT_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pcst_pkg::t_dp_op               i_op,
    input  logic [COUNT_BITS-1:0]          i_cell_count,
    input  logic [pcst_pkg::CFG_IDXW-1:0]  i_cfg_index,
    input  logic [pcst_pkg::CFGW-1:0]      i_cfg_data,
    output pcst_pkg::t_dp_status           o_status,
    output logic [pcst_pkg::OUT_W-1:0]     o_chi_square,
    output logic                           o_degenerate
);
    import pcst_pkg::*;

    localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int IDXW  = $clog2(CELLS);
    localparam int CW    = COUNT_BITS;
    localparam int RSW   = CW + CIW;
    localparam int CSW   = CW + RIW;
    localparam int NW    = CW + IDXW;
    localparam int AW    = NW + CW;
    localparam int BW    = RSW + CSW;
    localparam int DW    = (AW > BW) ? AW : BW;
    localparam int PW    = 2 * DW;
    localparam int DENW  = NW + BW;
    localparam int SHW   = FRAC_BITS + GUARD_BITS;
    localparam int NUMW  = PW + SHW;
    localparam int CNTW  = $clog2(NUMW);
    localparam int QW    = (NUMW > ACC_W) ? NUMW : ACC_W;
    localparam int RW    = (RIW > CFGW) ? RIW : CFGW;
    localparam int CCW   = (CIW > CFGW) ? CIW : CFGW;
    localparam int RESW  = ACC_W - GUARD_BITS;

    localparam logic [ACC_W-1:0] ACC_MAX = '1;
    localparam logic [ACC_W-1:0] HALF    = ACC_W'(1) << (GUARD_BITS - 1);
    localparam logic [RESW-1:0]  OUT_MAX = RESW'({OUT_W{1'b1}});

    logic [CW-1:0]   mem [CELLS];

    logic [CFGW-1:0] r_rows, r_cols;
    logic [RSW-1:0]  r_row_sum [MAX_ROWS];
    logic [CSW-1:0]  r_col_sum [MAX_COLS];
    logic [NW-1:0]   r_total;
    logic [RIW-1:0]  r_lr, r_kr;
    logic [CIW-1:0]  r_lc, r_kc;
    logic [IDXW-1:0] r_widx, r_k;
    logic [ACC_W-1:0] r_acc;

    logic [CW-1:0]   r_rd;
    logic [RSW-1:0]  r_rsel;
    logic [CSW-1:0]  r_csel;
    logic [AW-1:0]   r_a;
    logic [BW-1:0]   r_b;
    logic [DW-1:0]   r_d;
    logic [PW-1:0]   r_mcand, r_prod;
    logic [DW-1:0]   r_mplier;
    logic [NUMW-1:0] r_num;
    logic [DENW-1:0] r_den;
    logic [DENW-1:0] r_rem;
    logic [CNTW-1:0] r_cnt;
    logic [OUT_W-1:0] r_chi;
    logic            r_degen;

    logic [CFGW-1:0] nr_m1, nc_m1;
    logic            lr_last, lc_last, kr_last, kc_last;
    logic            any_zero;
    logic            clear;
    logic [DENW:0]   rem_sh;
    logic            q_bit;
    logic [QW-1:0]   q_ext;
    logic [ACC_W-1:0] q_sat;
    logic [ACC_W:0]  acc_sum;
    logic [ACC_W:0]  acc_rnd;
    logic [RESW-1:0] res;

    always_comb begin
        if (r_rows < CFGW'(2))             nr_m1 = CFGW'(1);
        else if (32'(r_rows) > MAX_ROWS)   nr_m1 = CFGW'(MAX_ROWS - 1);
        else                               nr_m1 = r_rows - CFGW'(1);
        if (r_cols < CFGW'(2))             nc_m1 = CFGW'(1);
        else if (32'(r_cols) > MAX_COLS)   nc_m1 = CFGW'(MAX_COLS - 1);
        else                               nc_m1 = r_cols - CFGW'(1);
    end

    assign lr_last = RW'(r_lr) == RW'(nr_m1);
    assign lc_last = CCW'(r_lc) == CCW'(nc_m1);
    assign kr_last = RW'(r_kr) == RW'(nr_m1);
    assign kc_last = CCW'(r_kc) == CCW'(nc_m1);

    always_comb begin
        any_zero = (r_total == '0);
        for (int i = 0; i < MAX_ROWS; i++) begin
            if (i <= 32'(nr_m1) && r_row_sum[i] == '0) any_zero = 1'b1;
        end
        for (int j = 0; j < MAX_COLS; j++) begin
            if (j <= 32'(nc_m1) && r_col_sum[j] == '0) any_zero = 1'b1;
        end
    end

    assign o_status.last_cell = lr_last && lc_last;
    assign o_status.degen     = any_zero;
    assign o_status.last_k    = kr_last && kc_last;
    assign o_status.step_last = (r_cnt == '0);

    assign clear = (i_op == OP_RESULT) || (i_op == OP_RESULT_DEGEN) ||
                   ((i_op == OP_CFG) && ((i_cfg_index == REG_ROWS) ||
                                         (i_cfg_index == REG_COLS)));

    assign rem_sh  = {r_rem, r_num[NUMW-1]};
    assign q_bit   = rem_sh >= {1'b0, r_den};
    assign q_ext   = QW'(r_num);
    assign q_sat   = ((q_ext >> ACC_W) != '0) ? ACC_MAX : ACC_W'(q_ext);
    assign acc_sum = {1'b0, r_acc} + {1'b0, q_sat};
    assign acc_rnd = {1'b0, r_acc} + {1'b0, HALF};

    always_comb begin
        if (r_acc > (ACC_MAX - HALF)) res = RESW'(ACC_MAX >> GUARD_BITS);
        else                          res = acc_rnd[ACC_W-1:GUARD_BITS];
    end

    // control state and table sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= ROWS_RESET;
            r_cols  <= COLS_RESET;
            r_total <= '0;
            r_lr    <= '0;
            r_lc    <= '0;
            r_widx  <= '0;
            r_kr    <= '0;
            r_kc    <= '0;
            r_k     <= '0;
            r_acc   <= '0;
            for (int i = 0; i < MAX_ROWS; i++) r_row_sum[i] <= '0;
            for (int j = 0; j < MAX_COLS; j++) r_col_sum[j] <= '0;
        end else if (clear) begin
            if (i_op == OP_CFG && i_cfg_index == REG_ROWS) r_rows <= i_cfg_data;
            if (i_op == OP_CFG && i_cfg_index == REG_COLS) r_cols <= i_cfg_data;
            r_total <= '0;
            r_lr    <= '0;
            r_lc    <= '0;
            r_widx  <= '0;
            r_kr    <= '0;
            r_kc    <= '0;
            r_k     <= '0;
            r_acc   <= '0;
            for (int i = 0; i < MAX_ROWS; i++) r_row_sum[i] <= '0;
            for (int j = 0; j < MAX_COLS; j++) r_col_sum[j] <= '0;
        end else if (i_op == OP_LOAD) begin
            r_row_sum[r_lr] <= r_row_sum[r_lr] + RSW'(i_cell_count);
            r_col_sum[r_lc] <= r_col_sum[r_lc] + CSW'(i_cell_count);
            r_total         <= r_total + NW'(i_cell_count);
            if (lc_last) begin
                r_lc <= '0;
                r_lr <= lr_last ? '0 : r_lr + RIW'(1);
            end else begin
                r_lc <= r_lc + CIW'(1);
            end
            r_widx <= (lr_last && lc_last) ? '0 : r_widx + IDXW'(1);
        end else if (i_op == OP_ACC) begin
            r_acc <= acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
            if (kc_last) begin
                r_kc <= '0;
                r_kr <= kr_last ? '0 : r_kr + RIW'(1);
            end else begin
                r_kc <= r_kc + CIW'(1);
            end
            r_k <= (kr_last && kc_last) ? '0 : r_k + IDXW'(1);
        end
    end

    // cell memory
    always_ff @(posedge i_clk) begin
        if (i_op == OP_LOAD) mem[r_widx] <= i_cell_count;
        if (i_op == OP_READ) r_rd <= mem[r_k];
    end

    // arithmetic
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            case (i_op)
                OP_READ: begin
                    r_rsel <= r_row_sum[r_kr];
                    r_csel <= r_col_sum[r_kc];
                end
                OP_PROD: begin
                    r_a <= AW'(r_total) * AW'(r_rd);
                    r_b <= BW'(r_rsel) * BW'(r_csel);
                end
                OP_DIFF: begin
                    r_d <= (DW'(r_a) >= DW'(r_b)) ? DW'(r_a) - DW'(r_b)
                                                  : DW'(r_b) - DW'(r_a);
                end
                OP_MSTART_DD: begin
                    r_mcand  <= PW'(r_d);
                    r_mplier <= r_d;
                    r_prod   <= '0;
                    r_cnt    <= CNTW'(DW - 1);
                end
                OP_MSTART_DEN: begin
                    r_num    <= {r_prod, SHW'(0)};
                    r_mcand  <= PW'(r_b);
                    r_mplier <= DW'(r_total);
                    r_prod   <= '0;
                    r_cnt    <= CNTW'(DW - 1);
                end
                OP_MSTEP: begin
                    if (r_mplier[0]) r_prod <= r_prod + r_mcand;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt - CNTW'(1);
                end
                OP_DSTART: begin
                    r_den <= DENW'(r_prod);
                    r_rem <= '0;
                    r_cnt <= CNTW'(NUMW - 1);
                end
                OP_DSTEP: begin
                    r_rem <= q_bit ? DENW'(rem_sh - {1'b0, r_den}) : rem_sh[DENW-1:0];
                    r_num <= {r_num[NUMW-2:0], q_bit};
                    r_cnt <= r_cnt - CNTW'(1);
                end
                OP_RESULT: begin
                    r_chi   <= (res > OUT_MAX) ? OUT_MAX[OUT_W-1:0] : res[OUT_W-1:0];
                    r_degen <= 1'b0;
                end
                OP_RESULT_DEGEN: begin
                    r_chi   <= '0;
                    r_degen <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_chi_square = r_chi;
    assign o_degenerate = r_degen;

endmodule

>>> hdl/pearson_chi_square_table.sv
// Pearson chi-square statistic of an R-by-C contingency table.
// Loading takes one cell per cycle while no register write is offered. After the last cell,
// unless the table is degenerate, the block computes each cell in turn with a serial multiplier
// and a one-bit-a-cycle divider. Input is held off during that phase; the result waits in an
// output register. Reset (synchronous, active low) clears sums, counters and result valid;
// no clearing pass.
module pearson_chi_square_table #(
    parameter int MAX_ROWS   = 4,
    parameter int MAX_COLS   = 4,
    parameter int COUNT_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cell_valid,
    output logic                           o_cell_stall,
    input  logic [COUNT_BITS-1:0]          i_cell_count,
    output logic                           o_res_valid,
    input  logic                           i_res_stall,
    output logic [pcst_pkg::OUT_W-1:0]     o_chi_square,
    output logic                           o_degenerate,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pcst_pkg::CFG_IDXW-1:0]  i_cfg_index,
    input  logic [pcst_pkg::CFGW-1:0]      i_cfg_data
);
    import pcst_pkg::*;

    t_dp_op     op;
    t_dp_status status;

    pcst_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cell_valid (i_cell_valid),
        .o_cell_stall (o_cell_stall),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .o_res_valid  (o_res_valid),
        .i_res_stall  (i_res_stall),
        .i_status     (status),
        .o_op         (op)
    );

    pcst_dp #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (op),
        .i_cell_count (i_cell_count),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_status     (status),
        .o_chi_square (o_chi_square),
        .o_degenerate (o_degenerate)
    );

endmodule

>>> hdl/pcst_chk.sv
// Port checker for the Pearson chi-square table block, bound to the top level.
// Depends on pcst_pkg.
module pcst_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cell_valid,
    input logic                           o_cell_stall,
    input logic                           o_res_valid,
    input logic                           i_res_stall,
    input logic [pcst_pkg::OUT_W-1:0]     o_chi_square,
    input logic                           o_degenerate,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready
);
    import pcst_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=> o_res_valid)
        else $error("item dropped while stalled");

    a_hold_chi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=> $stable(o_chi_square) && $stable(o_degenerate))
        else $error("stalled item changed");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_degenerate |-> o_chi_square == '0)
        else $error("degenerate item with nonzero statistic");

    a_cfg_blocks_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready && i_cfg_valid |-> !(i_cell_valid && !o_cell_stall))
        else $error("cell taken with a register write");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid && o_cfg_ready)
        else $error("not idle after reset");

endmodule

bind pearson_chi_square_table pcst_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cell_valid (i_cell_valid),
    .o_cell_stall (o_cell_stall),
    .o_res_valid  (o_res_valid),
    .i_res_stall  (i_res_stall),
    .o_chi_square (o_chi_square),
    .o_degenerate (o_degenerate),
    .i_cfg_valid  (i_cfg_valid),
    .o_cfg_ready  (o_cfg_ready)
);

>>> bench/tb.sv
// Self-checking bench for pearson_chi_square_table: cell counts go in row-major order and each
// finished table is checked against an expected chi-square computed here in wide integer arithmetic.
// Depends on pcst_pkg and the pearson_chi_square_table RTL.
`timescale 1ns / 100ps

module tb;
    import pcst_pkg::*;

    localparam int           RUN_LIMIT  = 3_000_000;
    localparam int           RAND_ITEMS = 450;
    localparam logic [1:0]   REG_SPARE2 = 2'd2;
    localparam logic [1:0]   REG_SPARE3 = 2'd3;

    typedef struct {
        logic [OUT_W-1:0] chi;
        logic             degen;
    } t_stat;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cell_valid = 1'b0;
    logic [15:0]          cell_count = '0;
    logic                 res_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDXW-1:0]  cfg_index = '0;
    logic [CFGW-1:0]      cfg_data = '0;
    logic                 o_cell_stall, o_res_valid, o_degenerate, o_cfg_ready;
    logic [OUT_W-1:0]     o_chi_square;

    pearson_chi_square_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cell_valid(cell_valid), .o_cell_stall(o_cell_stall), .i_cell_count(cell_count),
        .o_res_valid(o_res_valid), .i_res_stall(res_stall),
        .o_chi_square(o_chi_square), .o_degenerate(o_degenerate),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // table model
    logic [CFGW-1:0] rows_reg = ROWS_RESET, cols_reg = COLS_RESET;
    logic [15:0]     cells [16];
    logic [17:0]     row_tot [4];
    logic [17:0]     col_tot [4];
    logic [19:0]     n_tot;
    int              next_cell;
    t_stat           stat_q [$];

    int  errors = 0;
    int  results_seen = 0;
    int  cycles = 0;
    int  burst_left = 0;
    bit  bursty = 1'b1;
    bit  hold_req = 1'b0;
    bit  stall_on = 1'b1;

    function automatic int dim_of(input logic [CFGW-1:0] v);
        if (v < 2) return 2;
        if (v > 4) return 4;
        return int'(v);
    endfunction

    task automatic clear_table();
        for (int k = 0; k < 4; k++) begin
            row_tot[k] = '0;
            col_tot[k] = '0;
        end
        n_tot = '0;
        next_cell = 0;
    endtask

    task automatic predict_chi(input logic [15:0] v);
        int nr, nc, r, c;
        bit degen;
        logic [127:0] a, b, d, den, q;
        logic [63:0] acc, res;
        t_stat s;
        nr = dim_of(rows_reg);
        nc = dim_of(cols_reg);
        if (next_cell >= nr * nc) next_cell = 0;
        r = next_cell / nc;
        c = next_cell % nc;
        cells[r * 4 + c] = v;
        row_tot[r] += v;
        col_tot[c] += v;
        n_tot += v;
        next_cell++;
        if (next_cell < nr * nc) return;
        degen = (n_tot == 0);
        for (int k = 0; k < nr; k++) if (row_tot[k] == 0) degen = 1'b1;
        for (int k = 0; k < nc; k++) if (col_tot[k] == 0) degen = 1'b1;
        acc = '0;
        if (!degen) begin
            for (int i = 0; i < nr; i++) begin
                for (int j = 0; j < nc; j++) begin
                    a = 128'(n_tot) * 128'(cells[i * 4 + j]);
                    b = 128'(row_tot[i]) * 128'(col_tot[j]);
                    d = (a >= b) ? a - b : b - a;
                    d = (d * d) << 24;
                    den = 128'(n_tot) * b;
                    q = d / den;
                    if (q[127:64] != 0) q = {64'd0, {64{1'b1}}};
                    if (acc > {64{1'b1}} - q[63:0]) acc = {64{1'b1}};
                    else acc = acc + q[63:0];
                end
            end
        end
        if (acc > {64{1'b1}} - 64'd128) res = {64{1'b1}} >> GUARD_BITS;
        else res = (acc + 64'd128) >> GUARD_BITS;
        s.degen = degen;
        s.chi = degen ? '0 : (res > 64'(41'h0FF_FFFF_FFFF) ? {OUT_W{1'b1}} : res[OUT_W-1:0]);
        stat_q.push_back(s);
        clear_table();
    endtask

    task automatic send_cell(input logic [15:0] v);
        int gap;
        if (bursty && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            cell_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        if (burst_left > 0) burst_left--;
        cell_valid <= 1'b1;
        cell_count <= v;
        @(posedge i_clk);
        while (o_cell_stall) @(posedge i_clk);
        predict_chi(v);
    endtask

    task automatic wait_idle();
        cell_valid <= 1'b0;
        while (stat_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDXW-1:0] idx, input logic [CFGW-1:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        if (idx == REG_ROWS) rows_reg = val;
        else if (idx == REG_COLS) cols_reg = val;
        if (idx == REG_ROWS || idx == REG_COLS) clear_table();
    endtask

    function automatic logic [15:0] rand_count();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_table();
        int n, zr;
        n = dim_of(rows_reg) * dim_of(cols_reg);
        zr = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, n - 1)) : -1;
        for (int k = 0; k < n; k++)
            send_cell((k == zr || (zr >= 0 && k % dim_of(cols_reg) == zr % dim_of(cols_reg)))
                      ? 16'd0 : rand_count());
    endtask

    task automatic test_directed();
        for (int k = 0; k < 6; k++) send_cell(16'd0);
        for (int k = 0; k < 6; k++) send_cell(16'hFFFF);
        for (int k = 0; k < 6; k++) send_cell((k % 3 == 1) ? 16'd0 : 16'd7);
        for (int k = 0; k < 6; k++) send_cell((k == 0 || k == 4) ? 16'hFFFF : 16'd1);
    endtask

    task automatic test_config_sweep();
        logic [CFGW-1:0] r_vals [6] = '{3'd2, 3'd4, 3'd0, 3'd7, 3'd1, 3'd3};
        logic [CFGW-1:0] c_vals [6] = '{3'd2, 3'd4, 3'd7, 3'd1, 3'd5, 3'd2};
        for (int k = 0; k < 6; k++) begin
            write_reg(REG_ROWS, r_vals[k]);
            write_reg(REG_COLS, c_vals[k]);
            send_table();
            send_cell(16'd5);
            write_reg(REG_SPARE2, 3'd6);
            write_reg(REG_SPARE3, 3'd4);
            send_table();
        end
    endtask

    task automatic test_backpressure();
        write_reg(REG_ROWS, 3'd2);
        write_reg(REG_COLS, 3'd2);
        hold_req = 1'b1;
        for (int k = 0; k < 4; k++) send_table();
        wait_idle();
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < RAND_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                write_reg(REG_ROWS, ($urandom_range(0, 7) == 0) ? 3'(4) : 3'($urandom_range(0, 3)));
                write_reg(REG_COLS, ($urandom_range(0, 7) == 0) ? 3'(4)
                                    : 3'($urandom_range(0, 7)));
                bursty = ($urandom_range(0, 2) != 0);
                stall_on = ($urandom_range(0, 2) != 0);
            end
            send_table();
            sent += dim_of(rows_reg) * dim_of(cols_reg);
            if ($urandom_range(0, 15) == 0) begin
                send_cell(rand_count());
                sent++;
            end
        end
        wait_idle();
    endtask

    always @(posedge i_clk) begin
        int hold;
        if (hold_req) begin
            hold_req = 1'b0;
            res_stall <= 1'b1;
            for (hold = 0; hold < 8000; hold++) @(posedge i_clk);
            res_stall <= 1'b0;
        end else begin
            res_stall <= stall_on && ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge i_clk) begin
        t_stat s;
        if (o_res_valid && !res_stall) begin
            results_seen++;
            if (stat_q.size() == 0) begin
                $error("result with none expected: chi_square %0d degenerate %0d",
                       o_chi_square, o_degenerate);
                errors++;
            end else begin
                s = stat_q.pop_front();
                if (o_chi_square !== s.chi) begin
                    $error("chi_square expected %0d actual %0d", s.chi, o_chi_square);
                    errors++;
                end
                if (o_degenerate !== s.degen) begin
                    $error("degenerate expected %0d actual %0d", s.degen, o_degenerate);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("FAIL pearson_chi_square_table");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < 16; k++) cells[k] = '0;
        clear_table();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_sweep();
        test_backpressure();
        test_random();
        if (errors == 0 && stat_q.size() == 0) begin
            $display("PASS pearson_chi_square_table");
        end else begin
            $display("FAIL pearson_chi_square_table");
        end
        $finish;
    end

endmodule
